@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("%m: invariant violated");

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/frgc_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame rate and game clock package
// Field widths, request and mode codes, and fixed constants.
// ----------------------------------------------------------------------------
package frgc_pkg;

  localparam int TS_W   = 32;
  localparam int TIME_W = 48;
  localparam int FPS_W  = 22;
  localparam int SEC_W  = 16;
  localparam int OP_W   = 2;
  localparam int MODE_W = 2;

  localparam logic [FPS_W-1:0] FPS_MAX      = '1;
  localparam logic [SEC_W-1:0] SEC_CNT_MAX  = '1;
  localparam logic [SEC_W-1:0] PERIOD_RESET = 16'd1000;

  // 1000 frames per second scaled by 2^8 fraction bits
  localparam int RATE_SCALE = 256000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_RUN   = 2'd1,
    OP_PAUSE = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_RUN   = 2'd0,
    MODE_PAUSE = 2'd1,
    MODE_STOP  = 2'd2
  } clk_mode_e;

endpackage

@@ rtl/frame_rate_and_game_clock_top.sv @@
// Frame rate meter and game clock. Each request is a frame tick carrying a
// millisecond timestamp, or a run, pause or stop command; every request gives
// exactly one result. A request holds off the next one while it passes through
// ST_UPDATE, ST_PREP and ST_DIV until its result is in the output register.
// The rate 256000 * filled / sum comes from a restoring divider that produces
// one quotient bit per cycle on a NUM_W-bit numerator, where NUM_W is the width
// of 256000 * WINDOW but at least 22. The interval ring is a memory of WINDOW
// entries with no clearing pass; entries not yet written are never used, as
// the fill count tells which are live. A finished result is held in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
// Frame rate and game clock - top level
// Interval ring, running sum, serial rate divider, real and game counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_rate_and_game_clock_top #(
  parameter int WINDOW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [frgc_pkg::SEC_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [frgc_pkg::OP_W-1:0]     operation_i,
  input  logic [frgc_pkg::TS_W-1:0]     timestamp_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [frgc_pkg::FPS_W-1:0]    fps_fixed_o,
  output logic [frgc_pkg::TS_W-1:0]     real_delta_ms_o,
  output logic [frgc_pkg::TS_W-1:0]     game_delta_ms_o,
  output logic [frgc_pkg::TIME_W-1:0]   real_time_ms_o,
  output logic [frgc_pkg::TIME_W-1:0]   game_time_ms_o,
  output logic [frgc_pkg::SEC_W-1:0]    frames_this_second_o,
  output logic [frgc_pkg::TS_W-1:0]     real_frame_total_o,
  output logic [frgc_pkg::TS_W-1:0]     game_frame_total_o,
  output logic [frgc_pkg::MODE_W-1:0]   clock_mode_o
);

  import frgc_pkg::*;

  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SUM_W   = TS_W + $clog2(WINDOW);
  localparam int NUM_RAW = $clog2(RATE_SCALE * WINDOW + 1);
  localparam int NUM_W   = (NUM_RAW > FPS_W) ? NUM_RAW : FPS_W;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV
  } state_e;

  // the result is loaded from ST_DIV's last step onward, held in ST_DONE-like
  // waiting inside ST_DIV with cnt at zero
  state_e                state_q;
  op_e                   op_q;
  logic [TS_W-1:0]       ts_q;
  logic [SEC_W-1:0]      period_q;

  // interval ring
  logic [TS_W-1:0]       ring_mem [WINDOW];
  logic [TS_W-1:0]       ring_rd_q;
  logic [IDX_W-1:0]      idx_q;
  logic [FILL_W-1:0]     filled_q;
  logic [SUM_W-1:0]      sum_q;
  logic [TS_W-1:0]       newest_q;

  // clock state
  logic [TS_W-1:0]       prev_ts_q;
  logic [TS_W-1:0]       sec_start_q;
  logic [SEC_W-1:0]      sec_cnt_q;
  logic [TS_W-1:0]       real_frames_q;
  logic [TS_W-1:0]       game_frames_q;
  logic [TIME_W-1:0]     real_time_q;
  logic [TIME_W-1:0]     game_time_q;
  logic [TS_W-1:0]       game_delta_q;
  clk_mode_e             mode_q;

  // divider
  logic [NUM_W-1:0]      num_q;
  logic [SUM_W-1:0]      rem_q;
  logic [CNT_W-1:0]      cnt_q;

  // result register
  logic                  out_valid_q;
  logic [FPS_W-1:0]      fps_q;
  logic [TS_W-1:0]       o_real_delta_q;
  logic [TS_W-1:0]       o_game_delta_q;
  logic [TIME_W-1:0]     o_real_time_q;
  logic [TIME_W-1:0]     o_game_time_q;
  logic [SEC_W-1:0]      o_sec_cnt_q;
  logic [TS_W-1:0]       o_real_frames_q;
  logic [TS_W-1:0]       o_game_frames_q;
  clk_mode_e             o_mode_q;

  logic                  in_accept;
  logic                  ring_full;
  logic                  tick;
  logic [TS_W-1:0]       delta;
  logic [TS_W-1:0]       old_dur;
  logic [TS_W-1:0]       elapsed;
  logic                  period_hit;
  logic [SEC_W-1:0]      sec_cnt_inc;
  logic [IDX_W-1:0]      idx_next;
  logic [SUM_W:0]        trial;
  logic [SUM_W:0]        trial_diff;
  logic                  trial_ge;
  logic                  div_last;
  logic                  out_free;
  logic [FPS_W-1:0]      fps_result;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ring_full  = (filled_q == FILL_W'(WINDOW));
  assign tick       = (op_q == OP_TICK);
  assign delta      = ts_q - prev_ts_q;
  // slots below the fill count were written in order; only a full ring has
  // a live entry at the write index
  assign old_dur    = ring_full ? ring_rd_q : '0;
  assign elapsed    = ts_q - sec_start_q;
  assign period_hit = (elapsed >= TS_W'(period_q));
  assign sec_cnt_inc = (sec_cnt_q != SEC_CNT_MAX) ? sec_cnt_q + 1'b1 : sec_cnt_q;
  assign idx_next   = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;

  // restoring divider step
  assign trial      = {rem_q, num_q[NUM_W-1]};
  assign trial_diff = trial - {1'b0, sum_q};
  assign trial_ge   = !trial_diff[SUM_W];
  assign div_last   = (state_q == ST_DIV) && (cnt_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    priority if (filled_q == '0) begin
      fps_result = '0;
    end else if (sum_q == '0) begin
      fps_result = FPS_MAX;
    end else if (num_q > NUM_W'(FPS_MAX)) begin
      fps_result = FPS_MAX;
    end else begin
      fps_result = num_q[FPS_W-1:0];
    end
  end

  // ring memory: one write port, one registered read port at the write index
  always_ff @(posedge clk_i) begin
    ring_rd_q <= ring_mem[idx_q];
    if (state_q == ST_UPDATE && tick) begin
      ring_mem[idx_q] <= delta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_TICK;
      ts_q          <= '0;
      idx_q         <= '0;
      filled_q      <= '0;
      sum_q         <= '0;
      newest_q      <= '0;
      prev_ts_q     <= '0;
      sec_start_q   <= '0;
      sec_cnt_q     <= '0;
      real_frames_q <= '0;
      game_frames_q <= '0;
      real_time_q   <= '0;
      game_time_q   <= '0;
      game_delta_q  <= '0;
      mode_q        <= MODE_STOP;
      num_q         <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (div_last && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            op_q    <= op_e'(operation_i);
            ts_q    <= timestamp_ms_i;
            state_q <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          unique case (op_q)
            OP_TICK: begin
              prev_ts_q     <= ts_q;
              sum_q         <= sum_q - SUM_W'(old_dur) + SUM_W'(delta);
              newest_q      <= delta;
              idx_q         <= idx_next;
              if (!ring_full) begin
                filled_q <= filled_q + 1'b1;
              end
              real_frames_q <= real_frames_q + 1'b1;
              real_time_q   <= real_time_q + TIME_W'(delta);
              if (mode_q == MODE_RUN) begin
                game_frames_q <= game_frames_q + 1'b1;
                game_delta_q  <= delta;
                game_time_q   <= game_time_q + TIME_W'(delta);
              end
              // restart the count at zero if the period has run out, else count the frame
              if (period_hit) begin
                sec_cnt_q   <= '0;
                sec_start_q <= ts_q;
              end else begin
                sec_cnt_q   <= sec_cnt_inc;
              end
            end
            OP_RUN: begin
              mode_q <= MODE_RUN;
            end
            OP_PAUSE: begin
              mode_q       <= MODE_PAUSE;
              game_delta_q <= '0;
            end
            OP_STOP: begin
              mode_q        <= MODE_STOP;
              game_delta_q  <= '0;
              game_time_q   <= '0;
              game_frames_q <= '0;
            end
            default: ;
          endcase
          state_q <= ST_PREP;
        end

        ST_PREP: begin
          num_q   <= NUM_W'(RATE_SCALE) * NUM_W'(filled_q);
          rem_q   <= '0;
          cnt_q   <= CNT_W'(NUM_W);
          state_q <= ST_DIV;
        end

        ST_DIV: begin
          if (cnt_q != '0) begin
            num_q <= {num_q[NUM_W-2:0], trial_ge};
            rem_q <= trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            cnt_q <= cnt_q - 1'b1;
          end else if (out_free) begin
            // quotient complete; hand it over once the result register is free
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_last && out_free) begin
      fps_q           <= fps_result;
      o_real_delta_q  <= newest_q;
      o_game_delta_q  <= game_delta_q;
      o_real_time_q   <= real_time_q;
      o_game_time_q   <= game_time_q;
      o_sec_cnt_q     <= sec_cnt_q;
      o_real_frames_q <= real_frames_q;
      o_game_frames_q <= game_frames_q;
      o_mode_q        <= mode_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign fps_fixed_o          = fps_q;
  assign real_delta_ms_o      = o_real_delta_q;
  assign game_delta_ms_o      = o_game_delta_q;
  assign real_time_ms_o       = o_real_time_q;
  assign game_time_ms_o       = o_game_time_q;
  assign frames_this_second_o = o_sec_cnt_q;
  assign real_frame_total_o   = o_real_frames_q;
  assign game_frame_total_o   = o_game_frames_q;
  assign clock_mode_o         = o_mode_q;

  // ---- assertions ----
  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, filled_q <= FILL_W'(WINDOW))
  `ASSERT_IMPL(a_idx_tracks_fill, clk_i, rst_ni, !ring_full, idx_q == filled_q[IDX_W-1:0])
  `ASSERT_IMPL(a_stop_clears_game, clk_i, rst_ni, mode_q == MODE_STOP,
               (game_frames_q == '0) && (game_time_q == '0) && (game_delta_q == '0))
  `ASSERT_NEXT(a_accept_to_update, clk_i, rst_ni, in_accept, state_q == ST_UPDATE)
  `ASSERT_IMPL(a_sum_zero_when_empty, clk_i, rst_ni, filled_q == '0, sum_q == '0)

endmodule
